// File: src/pppb_pkg.sv
// ----------------------------------------------------------------------------
// pppb_pkg
// Shared widths, defaults, item codes and status types of the ping-pong
// byte buffer.
// ----------------------------------------------------------------------------
package pppb_pkg;

    localparam int unsigned BYTE_W             = 8;
    localparam int unsigned COUNT_W            = 13;
    localparam int unsigned DEFAULT_BANK_DEPTH = 4096;
    localparam logic [COUNT_W-1:0] RESET_BANK_BYTES = COUNT_W'(4096);

    // Input item kind, carried on tuser
    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_READ  = 1'b1
    } action_t;

    // Per-item status from the controller to the output pipeline
    typedef struct packed {
        logic               read_valid;
        logic               write_accepted;
        logic [COUNT_W-1:0] bytes_waiting;
    } pppb_res_t;

endpackage

// File: src/ping_pong_byte_buffer_top.sv
// One transfer per clock in each direction: a new item is taken every cycle
// while the output side keeps up. The bank RAM read and the status of an
// accepted item are registered at the accepting edge, then move into the
// output register behind m_tvalid once it is empty or being emptied.
// The sustained rate rests on each item making at most one bank RAM access.
// s_tready depends combinationally on m_tready. Both banks share one
// simple dual-port RAM of 2 x 2^clog2(BANK_DEPTH) bytes, addressed by bank
// select and position. bank_bytes is written through cfg_we/cfg_wdata; the
// user must write it only while the block is idle, as the block itself does
// not enforce it. 0 acts as 1, values above BANK_DEPTH act as BANK_DEPTH.
// ----------------------------------------------------------------------------
// ping_pong_byte_buffer_top
// Double-buffered byte store: writes fill one bank while reads drain the
// other; the banks swap when the drain bank runs empty.
// ----------------------------------------------------------------------------
module ping_pong_byte_buffer_top #(
    parameter int unsigned BANK_DEPTH = pppb_pkg::DEFAULT_BANK_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [pppb_pkg::COUNT_W-1:0] cfg_wdata,   // bank_bytes
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,     // [7:0] write_byte
    input  logic                         s_tuser,     // [0] action
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] read_byte, [8] read_valid, [9] write_accepted,
    // [22:10] bytes_waiting, [23] zero
    output logic [23:0]                  m_tdata
);

    import pppb_pkg::*;

    localparam int unsigned PW       = $clog2(BANK_DEPTH);
    localparam int unsigned RAM_DEPTH = 2 * (1 << PW);

    logic                item_acc;
    logic                mem_we;
    logic [PW:0]         mem_waddr;
    logic [BYTE_W-1:0]   mem_wdata;
    logic                mem_re;
    logic [PW:0]         mem_raddr;
    logic [BYTE_W-1:0]   mem_rdata;
    pppb_res_t           res;

    logic                p1_valid_reg, p1_valid_next;
    pppb_res_t           p1_res_reg;
    logic                p1_adv;
    logic                m_valid_reg,  m_valid_next;
    logic [23:0]         m_data_reg;
    logic [BYTE_W-1:0]   rd_byte;

    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || !m_valid_reg || m_tready;
    assign item_acc = s_tvalid && s_tready;

    pppb_ctrl #(
        .BANK_DEPTH (BANK_DEPTH)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_acc    (item_acc),
        .item_action (action_t'(s_tuser)),
        .item_byte   (s_tdata),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .res         (res)
    );

    pppb_bank_ram #(
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (item_acc) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (p1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        rd_byte = p1_res_reg.read_valid ? mem_rdata : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Hold status alongside the RAM read; advance into the output register
    always_ff @(posedge aclk) begin
        if (item_acc) begin
            p1_res_reg <= res;
        end
        if (p1_adv) begin
            m_data_reg <= {1'b0, p1_res_reg.bytes_waiting, p1_res_reg.write_accepted,
                           p1_res_reg.read_valid, rd_byte};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: src/pppb_bank_ram.sv
// ----------------------------------------------------------------------------
// pppb_bank_ram
// Simple dual-port byte RAM holding both banks: one write port, one read
// port with registered read data.
// ----------------------------------------------------------------------------
module pppb_bank_ram #(
    parameter int unsigned DEPTH = 2 * pppb_pkg::DEFAULT_BANK_DEPTH
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the last read byte until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/pppb_ctrl.sv
// ----------------------------------------------------------------------------
// pppb_ctrl
// Bank pointers, counts and swap logic. Turns each accepted item into at most
// one RAM access and its status word.
// ----------------------------------------------------------------------------
module pppb_ctrl #(
    parameter int unsigned BANK_DEPTH = pppb_pkg::DEFAULT_BANK_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pppb_pkg::COUNT_W-1:0]    cfg_wdata,
    input  logic                            item_acc,
    input  pppb_pkg::action_t               item_action,
    input  logic [pppb_pkg::BYTE_W-1:0]     item_byte,
    output logic                            mem_we,
    output logic [$clog2(BANK_DEPTH):0]     mem_waddr,
    output logic [pppb_pkg::BYTE_W-1:0]     mem_wdata,
    output logic                            mem_re,
    output logic [$clog2(BANK_DEPTH):0]     mem_raddr,
    output pppb_pkg::pppb_res_t             res
);

    import pppb_pkg::*;

    localparam int unsigned PW = $clog2(BANK_DEPTH);
    localparam int unsigned CNT_MAX = (1 << COUNT_W) - 1;
    localparam logic [COUNT_W-1:0] DEPTH_CAP =
        COUNT_W'((BANK_DEPTH > CNT_MAX) ? CNT_MAX : BANK_DEPTH);
    localparam logic [PW-1:0] POS_LAST = PW'(BANK_DEPTH - 1);

    logic [COUNT_W-1:0] bank_bytes_reg;
    logic               drain_sel_reg,   drain_sel_next;
    logic [PW-1:0]      drain_pos_reg,   drain_pos_next;
    logic [COUNT_W-1:0] drain_cnt_reg,   drain_cnt_next;
    logic [PW-1:0]      fill_pos_reg,    fill_pos_next;
    logic [COUNT_W-1:0] fill_cnt_reg,    fill_cnt_next;
    logic [COUNT_W-1:0] limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_bytes_reg <= RESET_BANK_BYTES;
        end else if (cfg_we) begin
            bank_bytes_reg <= cfg_wdata;
        end
    end

    always_comb begin
        if (bank_bytes_reg == '0) begin
            limit = COUNT_W'(1);
        end else if (bank_bytes_reg > DEPTH_CAP) begin
            limit = DEPTH_CAP;
        end else begin
            limit = bank_bytes_reg;
        end
    end

    always_comb begin
        logic           sel;
        logic [PW-1:0]  dpos;
        logic [COUNT_W-1:0] dcnt;
        logic [PW-1:0]  fpos;
        logic [COUNT_W-1:0] fcnt;

        sel  = drain_sel_reg;
        dpos = drain_pos_reg;
        dcnt = drain_cnt_reg;
        fpos = fill_pos_reg;
        fcnt = fill_cnt_reg;

        mem_we    = 1'b0;
        mem_waddr = {~drain_sel_reg, fill_pos_reg};
        mem_wdata = item_byte;
        mem_re    = 1'b0;
        mem_raddr = {drain_sel_reg, drain_pos_reg};
        res       = '0;

        if (item_acc) begin
            unique case (item_action)
                ACT_WRITE: begin
                    if (fcnt < limit) begin
                        mem_we = 1'b1;
                        fpos   = (fpos == POS_LAST) ? '0 : fpos + PW'(1);
                        fcnt   = fcnt + COUNT_W'(1);
                        res.write_accepted = 1'b1;
                    end
                end
                ACT_READ: begin
                    // Empty drain bank: swap before reading
                    if (dcnt == '0) begin
                        sel  = ~sel;
                        dpos = '0;
                        dcnt = fcnt;
                        fpos = '0;
                        fcnt = '0;
                    end
                    if (dcnt != '0) begin
                        mem_re         = 1'b1;
                        mem_raddr      = {sel, dpos};
                        res.read_valid = 1'b1;
                        dpos = (dpos == POS_LAST) ? '0 : dpos + PW'(1);
                        dcnt = dcnt - COUNT_W'(1);
                        // Drained the last byte: swap at once
                        if (dcnt == '0) begin
                            sel  = ~sel;
                            dpos = '0;
                            dcnt = fcnt;
                            fpos = '0;
                            fcnt = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        res.bytes_waiting = dcnt;
        drain_sel_next = sel;
        drain_pos_next = dpos;
        drain_cnt_next = dcnt;
        fill_pos_next  = fpos;
        fill_cnt_next  = fcnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drain_sel_reg <= 1'b0;
            drain_pos_reg <= '0;
            drain_cnt_reg <= '0;
            fill_pos_reg  <= '0;
            fill_cnt_reg  <= '0;
        end else begin
            drain_sel_reg <= drain_sel_next;
            drain_pos_reg <= drain_pos_next;
            drain_cnt_reg <= drain_cnt_next;
            fill_pos_reg  <= fill_pos_next;
            fill_cnt_reg  <= fill_cnt_next;
        end
    end

endmodule

// File: tb/sv/pppb_scoreboard.sv
// ----------------------------------------------------------------------------
// pppb_scoreboard
// Watches the configuration port and both streams of the ping-pong byte
// buffer, keeps its own copy of the two banks and their counters, and checks
// every result transfer against the oldest predicted one.
// ----------------------------------------------------------------------------
module pppb_scoreboard #(
    parameter int unsigned BANK_DEPTH = pppb_pkg::DEFAULT_BANK_DEPTH
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [pppb_pkg::COUNT_W-1:0] cfg_wdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [7:0]                   s_tdata,
    input  logic                         s_tuser,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [23:0]                  m_tdata,
    output int                           fail_count,
    output int                           results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import pppb_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        pppb_res_t         status;
    } byte_result_t;

    // Mirror of the buffer: both banks, roles and counters
    logic [BYTE_W-1:0]  bank_mem [2][BANK_DEPTH];
    logic               drain_sel;
    int unsigned        drain_pos;
    int unsigned        drain_count;
    int unsigned        fill_pos;
    int unsigned        fill_count;
    logic [COUNT_W-1:0] bank_bytes;

    byte_result_t       pending_results [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic swap_banks();
        drain_sel   = ~drain_sel;
        drain_pos   = 0;
        drain_count = fill_count;
        fill_pos    = 0;
        fill_count  = 0;
    endtask

    // Apply one item to the mirror and return the result it should produce
    task automatic step_buffer(input action_t act, input logic [BYTE_W-1:0] wbyte,
                               output byte_result_t res);
        int unsigned lim;
        lim = (bank_bytes == 0) ? 1 :
              ((bank_bytes > BANK_DEPTH) ? BANK_DEPTH : int'(bank_bytes));
        res = '0;
        if (act == ACT_WRITE) begin
            // a lowered limit leaves held bytes alone; the bank is full at or above it
            if (fill_count < lim) begin
                bank_mem[~drain_sel][fill_pos] = wbyte;
                fill_pos = (fill_pos + 1) % BANK_DEPTH;
                fill_count++;
                res.status.write_accepted = 1'b1;
            end
        end else begin
            if (drain_count == 0)
                swap_banks();
            if (drain_count > 0) begin
                res.read_byte         = bank_mem[drain_sel][drain_pos];
                res.status.read_valid = 1'b1;
                drain_pos = (drain_pos + 1) % BANK_DEPTH;
                drain_count--;
                if (drain_count == 0)
                    swap_banks();
            end
        end
        res.status.bytes_waiting = COUNT_W'(drain_count);
    endtask

    always @(posedge aclk) begin
        byte_result_t want;
        byte_result_t got;
        if (!aresetn) begin
            drain_sel   = 1'b0;
            drain_pos   = 0;
            drain_count = 0;
            fill_pos    = 0;
            fill_count  = 0;
            bank_bytes  = RESET_BANK_BYTES;
            fail_count  = 0;
            pending_results.delete();
            results_due <= 0;
        end else begin
            if (cfg_we)
                bank_bytes = cfg_wdata;

            if (m_tvalid && m_tready) begin
                got.read_byte                = m_tdata[7:0];
                got.status.read_valid        = m_tdata[8];
                got.status.write_accepted    = m_tdata[9];
                got.status.bytes_waiting     = m_tdata[22:10];
                if (pending_results.size() == 0) begin
                    report_mismatch("result transfers outstanding", 0, 1);
                end else begin
                    want = pending_results.pop_front();
                    if (got.read_byte !== want.read_byte)
                        report_mismatch("read_byte", int'(got.read_byte),
                                        int'(want.read_byte));
                    if (got.status.read_valid !== want.status.read_valid)
                        report_mismatch("read_valid", int'(got.status.read_valid),
                                        int'(want.status.read_valid));
                    if (got.status.write_accepted !== want.status.write_accepted)
                        report_mismatch("write_accepted", int'(got.status.write_accepted),
                                        int'(want.status.write_accepted));
                    if (got.status.bytes_waiting !== want.status.bytes_waiting)
                        report_mismatch("bytes_waiting", int'(got.status.bytes_waiting),
                                        int'(want.status.bytes_waiting));
                end
            end

            if (s_tvalid && s_tready) begin
                step_buffer(action_t'(s_tuser), s_tdata, want);
                pending_results.insert(pending_results.size(), want);
            end

            results_due <= pending_results.size();
        end
    end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the ping-pong byte buffer: a directed run through empty
// reads, dropped writes and bank swaps, then random write/read mixes under
// several bank sizes with random stalls on both streams. The scoreboard
// does the checking; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pppb_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;
    logic               s_tuser   = ACT_WRITE;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [23:0]        m_tdata;

    logic               steady_run = 1'b0;
    logic               hold_req   = 1'b0;
    int                 hold_left  = 0;
    int                 quiet_cycles = 0;
    int                 fail_count;
    int                 results_due;

    always #2 aclk = ~aclk;

    ping_pong_byte_buffer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    pppb_scoreboard scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else begin
            m_tready <= steady_run || ($urandom_range(99) >= 13);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one item and hold it until the transfer completes
    task automatic send_item(input action_t act, input logic [7:0] wbyte);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= wbyte;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0)
            @(posedge aclk);
    endtask

    task automatic set_bank_bytes(input logic [COUNT_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input logic [COUNT_W-1:0] limit, input int n_items,
                                input int write_pct, input bit hold_mid,
                                input bit drain_mid);
        set_bank_bytes(limit);
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) begin
                if (hold_mid) begin
                    // stall the receiver and keep offering so the block backs up
                    s_tvalid <= 1'b0;
                    hold_req <= 1'b1;
                    @(posedge aclk);
                    hold_req <= 1'b0;
                end
                if (drain_mid)
                    wait_drained();
            end
            if (!steady_run && $urandom_range(99) < 10) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 2)) @(posedge aclk);
            end
            send_item(($urandom_range(99) < write_pct) ? ACT_WRITE : ACT_READ,
                      8'($urandom_range(255)));
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset size: empty read, two writes, drain across the swap
        send_item(ACT_READ,  8'($urandom_range(255)));
        send_item(ACT_WRITE, 8'h00);
        send_item(ACT_WRITE, 8'hFF);
        send_item(ACT_READ,  8'($urandom_range(255)));
        send_item(ACT_READ,  8'($urandom_range(255)));
        send_item(ACT_READ,  8'($urandom_range(255)));

        // Zero acts as one byte per bank: second write drops
        set_bank_bytes('0);
        send_item(ACT_WRITE, 8'hA5);
        send_item(ACT_WRITE, 8'h5A);
        send_item(ACT_READ,  8'($urandom_range(255)));
        send_item(ACT_WRITE, 8'h3C);
        send_item(ACT_READ,  8'($urandom_range(255)));

        // Three per bank: fill past the limit, refill while draining
        set_bank_bytes(COUNT_W'(3));
        send_item(ACT_WRITE, 8'h01);
        send_item(ACT_WRITE, 8'h02);
        send_item(ACT_WRITE, 8'h04);
        send_item(ACT_WRITE, 8'h08);
        send_item(ACT_READ,  8'($urandom_range(255)));
        send_item(ACT_WRITE, 8'h10);
        send_item(ACT_READ,  8'($urandom_range(255)));
        send_item(ACT_READ,  8'($urandom_range(255)));
        send_item(ACT_READ,  8'($urandom_range(255)));
        send_item(ACT_READ,  8'($urandom_range(255)));

        random_phase(COUNT_W'(8191), 80, 55, 1'b0, 1'b0);
        random_phase(COUNT_W'(5),   150, 55, 1'b0, 1'b1);
        random_phase(COUNT_W'(1),    80, 50, 1'b0, 1'b0);
        random_phase(COUNT_W'(16),  150, 65, 1'b1, 1'b0);
        // lower the limit with bytes still held in the fill bank
        random_phase(COUNT_W'(2),   100, 45, 1'b0, 1'b0);
        random_phase(COUNT_W'(4096), 60, 50, 1'b0, 1'b0);
        steady_run <= 1'b1;
        random_phase(COUNT_W'(7),   150, 50, 1'b0, 1'b0);
        steady_run <= 1'b0;
        random_phase(COUNT_W'(4097), 50, 60, 1'b0, 1'b0);
        random_phase(COUNT_W'(3),   130, 50, 1'b0, 1'b0);

        wait_drained();
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: sim.f
src/pppb_pkg.sv
src/pppb_bank_ram.sv
src/pppb_ctrl.sv
src/ping_pong_byte_buffer_top.sv
tb/sv/pppb_scoreboard.sv
tb/sv/tb_top.sv
